// ===== rtl/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg: shared constants for the ordered list engine
// Capacity, derived widths, operation codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

   // Storage size and derived widths
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = ((CNT_W > 7) ? CNT_W : 7) + 1;

   // Operation codes
   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_REAR  = 3'd1;
   localparam logic [2:0] OP_DEL_FRONT = 3'd2;
   localparam logic [2:0] OP_DEL_REAR  = 3'd3;
   localparam logic [2:0] OP_INS_POS   = 3'd4;
   localparam logic [2:0] OP_DEL_POS   = 3'd5;
   localparam logic [2:0] OP_READ_POS  = 3'd6;
   localparam logic [2:0] OP_FIND      = 3'd7;

   // Status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_INVALID  = 3'd2;
   localparam logic [2:0] ST_BOUNDS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

endpackage

`default_nettype wire

// ===== rtl/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered sequence of signed 32-bit entries
// Packed entry memory plus a count. Inserts and deletes shift entries one
// per cycle through the memory port; find scans with one comparator.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_op, req_item_value, req_place
//  rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_read_value,
//                                           rsp_found_place, rsp_entry_count
//
//  A rejected request goes straight to the finish step; read passes through S_READ and S_RDATA.
//  Insert and delete shift the entries behind the place, one entry per cycle through
//  the memory's read and write port.
//  Find scans from the front and stops at the first match, or answers not found
//  after the last entry or at once on an empty list.
//  Reset clears the count, sequencer state and response valid; entry memory is not cleared.
//  Requests stall while one is in progress; a waiting response does not
//  block the next request, which finishes once the response register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [2:0]          req_op,
   input  wire  signed [31:0]  req_item_value,
   input  wire  [6:0]          req_place,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_read_value,
   output logic [6:0]          rsp_found_place,
   output logic [6:0]          rsp_entry_count
);

   localparam int AW = ole_pkg::ADDR_W;
   localparam int CW = ole_pkg::CNT_W;
   localparam int XW = ole_pkg::CMP_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SHIFT  = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_RDATA  = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       wa_ff, wa_in;
   logic                up_ff, up_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic signed [31:0]  val_ff, val_in;
   logic [2:0]          st_ff, st_in;
   logic signed [31:0]  rdv_ff, rdv_in;
   logic [6:0]          fnd_ff, fnd_in;

   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic signed [31:0]  rsp_read_value_ff;
   logic [6:0]          rsp_found_place_ff;
   logic [6:0]          rsp_entry_count_ff;
   logic                rsp_load;

   // Entry memory: one write and one registered read per cycle
   logic signed [31:0]  mem [ole_pkg::CAPACITY];
   logic signed [31:0]  rd_data_ff;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic signed [31:0]  wr_data;

   logic                accept;
   logic [XW-1:0]       p_ext, c_ext, cap_ext;
   logic                hit;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign p_ext     = XW'(req_place);
   assign c_ext     = XW'(count_ff);
   assign cap_ext   = XW'(ole_pkg::CAPACITY);
   assign hit       = pend_ff && (rd_data_ff == val_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ptr_ff];
   end

   // Sequencer and shared datapath
   always_comb begin
      logic          do_ins;
      logic          do_del;
      logic [AW-1:0] sel_idx;

      do_ins    = 1'b0;
      do_del    = 1'b0;
      sel_idx   = '0;
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      rem_in    = rem_ff;
      pend_in   = pend_ff;
      wa_in     = wa_ff;
      up_in     = up_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      st_in     = st_ff;
      rdv_in    = rdv_ff;
      fnd_in    = fnd_ff;
      wr_en     = 1'b0;
      wr_addr   = wa_ff;
      wr_data   = rd_data_ff;
      rsp_load  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_FINISH;
               val_in   = req_item_value;
               st_in    = ole_pkg::ST_OK;
               rdv_in   = '0;
               fnd_in   = '0;
               pend_in  = 1'b0;
               // decode the request and check it against the count
               unique case (req_op) inside
                  ole_pkg::OP_INS_FRONT, ole_pkg::OP_INS_REAR: begin
                     if (c_ext >= cap_ext) begin
                        st_in = ole_pkg::ST_FULL;
                     end else begin
                        do_ins  = 1'b1;
                        sel_idx = (req_op == ole_pkg::OP_INS_FRONT) ? '0 : AW'(count_ff);
                     end
                  end
                  ole_pkg::OP_DEL_FRONT, ole_pkg::OP_DEL_REAR: begin
                     if (count_ff == '0) begin
                        st_in = ole_pkg::ST_EMPTY;
                     end else begin
                        do_del  = 1'b1;
                        sel_idx = (req_op == ole_pkg::OP_DEL_FRONT) ? '0 :
                                  AW'(c_ext - XW'(1));
                     end
                  end
                  ole_pkg::OP_INS_POS: begin
                     if (req_place == '0) begin
                        st_in = ole_pkg::ST_INVALID;
                     end else if (c_ext >= cap_ext) begin
                        st_in = ole_pkg::ST_FULL;
                     end else if (p_ext > c_ext + XW'(1)) begin
                        st_in = ole_pkg::ST_BOUNDS;
                     end else begin
                        do_ins  = 1'b1;
                        sel_idx = AW'(p_ext - XW'(1));
                     end
                  end
                  ole_pkg::OP_DEL_POS: begin
                     if (count_ff == '0) begin
                        st_in = ole_pkg::ST_EMPTY;
                     end else if (req_place == '0) begin
                        st_in = ole_pkg::ST_INVALID;
                     end else if (p_ext > c_ext) begin
                        st_in = ole_pkg::ST_BOUNDS;
                     end else begin
                        do_del  = 1'b1;
                        sel_idx = AW'(p_ext - XW'(1));
                     end
                  end
                  ole_pkg::OP_READ_POS: begin
                     if (req_place == '0) begin
                        st_in = ole_pkg::ST_INVALID;
                     end else if (p_ext > c_ext) begin
                        st_in = ole_pkg::ST_BOUNDS;
                     end else begin
                        ptr_in   = AW'(p_ext - XW'(1));
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     ptr_in   = '0;
                     rem_in   = count_ff;
                     state_in = S_SCAN;
                  end
               endcase
               // set up the shift: insert moves the tail up, delete moves it down
               if (do_ins) begin
                  idx_in   = sel_idx;
                  up_in    = 1'b1;
                  rem_in   = CW'(c_ext - XW'(sel_idx));
                  ptr_in   = AW'(c_ext - XW'(1));
                  state_in = S_SHIFT;
               end else if (do_del) begin
                  idx_in   = sel_idx;
                  up_in    = 1'b0;
                  rem_in   = CW'(c_ext - XW'(1) - XW'(sel_idx));
                  ptr_in   = AW'(XW'(sel_idx) + XW'(1));
                  state_in = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            // write back the entry read last cycle, or finish the request
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff;
               wr_data = rd_data_ff;
            end else if (rem_ff == '0) begin
               if (up_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff;
                  wr_data  = val_ff;
                  count_in = count_ff + CW'(1);
               end else begin
                  count_in = count_ff - CW'(1);
               end
               state_in = S_FINISH;
            end
            // issue the next read
            if (rem_ff != '0) begin
               rem_in  = rem_ff - CW'(1);
               pend_in = 1'b1;
               wa_in   = up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
               ptr_in  = up_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end

         S_READ: begin
            state_in = S_RDATA;
         end

         S_RDATA: begin
            rdv_in   = rd_data_ff;
            state_in = S_FINISH;
         end

         S_SCAN: begin
            // compare the entry read last cycle, stop at the first match
            if (hit) begin
               fnd_in   = 7'(CW'(wa_ff) + CW'(1));
               st_in    = ole_pkg::ST_OK;
               state_in = S_FINISH;
            end else if (!pend_ff && rem_ff == '0) begin
               st_in    = ole_pkg::ST_NOTFOUND;
               state_in = S_FINISH;
            end
            if (rem_ff != '0) begin
               rem_in  = rem_ff - CW'(1);
               pend_in = 1'b1;
               wa_in   = ptr_ff;
               ptr_in  = ptr_ff + AW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end

         S_FINISH: begin
            // hand the result over once the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rem_ff <= rem_in;
      wa_ff  <= wa_in;
      up_ff  <= up_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
      st_ff  <= st_in;
      rdv_ff <= rdv_in;
      fnd_ff <= fnd_in;
      if (rsp_load) begin
         rsp_status_ff      <= st_ff;
         rsp_read_value_ff  <= rdv_ff;
         rsp_found_place_ff <= fnd_ff;
         rsp_entry_count_ff <= 7'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_found_place = rsp_found_place_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      XW'(count_ff) <= XW'(ole_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_count_only_in_shift: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> ($past(state_ff) == S_SHIFT))
      else $error("entry count changed outside a shift");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_FINISH))
      else $error("response raised outside the finish step");
`endif

endmodule

`default_nettype wire
